// File: src/rtf_txt_pkg.sv
`default_nettype none

package rtf_txt_pkg;

  localparam int unsigned NEST_BITS_DEF = 8;

  // results one document byte can cause
  localparam int unsigned MAX_EMIT = 5;
  localparam int unsigned CNT_W    = $clog2(MAX_EMIT + 1);

  localparam int unsigned HEAD_LEN = 5;
  localparam int unsigned KW_COUNT = 7;
  localparam int unsigned KW_QUOTE = 4;
  localparam int unsigned KW_TAB   = 5;
  localparam int unsigned KW_PAR   = 6;

  typedef enum logic [2:0] {
    MODE_HEADER,
    MODE_PASS,
    MODE_TEXT,
    MODE_ESCAPE,
    MODE_GROUP,
    MODE_END_PASS,
    MODE_END_RTF
  } mode_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // document header {\rtf
  localparam logic [7:0] HEAD_TEXT [HEAD_LEN] = '{8'h7b, 8'h5c, 8'h72, 8'h74, 8'h66};

  // control words matched after a backslash, zero padded
  localparam logic [7:0] KW_TEXT [KW_COUNT][16] = '{
    '{0:"f", 1:"o", 2:"n", 3:"t", 4:"t", 5:"b", 6:"l", default:8'h00},
    '{0:"f", 1:"i", 2:"l", 3:"e", 4:"t", 5:"b", 6:"l", default:8'h00},
    '{0:"c", 1:"o", 2:"l", 3:"o", 4:"r", 5:"t", 6:"b", 7:"l", default:8'h00},
    '{0:"s", 1:"t", 2:"y", 3:"l", 4:"e", 5:"s", 6:"h", 7:"e", 8:"e", 9:"t",
      default:8'h00},
    '{0:"'", 1:"a", 2:"0", default:8'h00},
    '{0:"t", 1:"a", 2:"b", default:8'h00},
    '{0:"p", 1:"a", 2:"r", default:8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd7, 4'd7, 4'd8, 4'd10, 4'd3, 4'd3, 4'd3};

  // bytes one document byte produces, handed to the result register
  typedef struct packed {
    logic [MAX_EMIT-1:0][7:0] bytes;
    logic [CNT_W-1:0]         cnt;
    logic                     rtf;
  } emit_t;

endpackage

`default_nettype wire

// File: src/rtf_txt_parser.sv
`default_nettype none

module rtf_txt_parser #(
  parameter int unsigned NEST_BITS = rtf_txt_pkg::NEST_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  output rtf_txt_pkg::emit_t      emit_o
);

  localparam int unsigned KWN = rtf_txt_pkg::KW_COUNT;

  rtf_txt_pkg::mode_e   mode_q, mode_n, mode_d;
  logic [2:0]           hc_q, hc_n, hc_d, hc_inc;
  logic [3:0]           wp_q, wp_n, wp_d, wp_inc;
  logic [KWN-1:0]       alive_q, alive_n, alive_d;
  logic [NEST_BITS-1:0] nest_q, nest_n, nest_d, nest_dec;

  logic [KWN-1:0] kw_hit;
  logic [KWN-1:0] kw_done;
  logic           grp_done, quote_done, tab_done, par_done;
  logic           head_match, esc_literal;

  assign hc_inc     = hc_q + 3'd1;
  assign wp_inc     = (wp_q == 4'hf) ? wp_q : wp_q + 4'd1;
  assign nest_dec   = (nest_q != '0) ? nest_q - NEST_BITS'(1) : nest_q;
  assign head_match = (hc_q < 3'(rtf_txt_pkg::HEAD_LEN))
                   && (byte_i == rtf_txt_pkg::HEAD_TEXT[hc_q]);
  assign esc_literal = (wp_q == 4'd0)
                    && (byte_i == rtf_txt_pkg::CH_LBRACE || byte_i == rtf_txt_pkg::CH_RBRACE
                     || byte_i == rtf_txt_pkg::CH_BSLASH || byte_i == rtf_txt_pkg::CH_TAB
                     || byte_i == rtf_txt_pkg::CH_LF);

  // candidate control words, one comparator each
  always_comb begin
    for (int k = 0; k < KWN; k++) begin
      kw_hit[k] = alive_q[k] && (wp_q < rtf_txt_pkg::KW_LEN[k])
               && ((byte_i == rtf_txt_pkg::KW_TEXT[k][wp_q])
                || (k == rtf_txt_pkg::KW_QUOTE && wp_q == 4'd1
                    && byte_i == rtf_txt_pkg::CH_UPPER_A));
      kw_done[k] = kw_hit[k] && ((5'(wp_q) + 5'd1) == 5'(rtf_txt_pkg::KW_LEN[k]));
    end
  end

  assign grp_done   = |kw_done[rtf_txt_pkg::KW_QUOTE-1:0];
  assign quote_done = kw_done[rtf_txt_pkg::KW_QUOTE];
  assign tab_done   = kw_done[rtf_txt_pkg::KW_TAB];
  assign par_done   = kw_done[rtf_txt_pkg::KW_PAR];

  // next state
  always_comb begin
    mode_n  = mode_q;
    hc_n    = hc_q;
    wp_n    = wp_q;
    alive_n = alive_q;
    nest_n  = nest_q;
    case (mode_q)
      rtf_txt_pkg::MODE_HEADER: begin
        if (head_match) begin
          hc_n = hc_inc;
          if (hc_inc == 3'(rtf_txt_pkg::HEAD_LEN)) begin
            // header read as an unknown control word
            mode_n  = rtf_txt_pkg::MODE_ESCAPE;
            alive_n = '0;
            wp_n    = 4'd3;
          end
        end else if (byte_i != rtf_txt_pkg::CH_NUL) begin
          mode_n = rtf_txt_pkg::MODE_PASS;
        end else begin
          mode_n = rtf_txt_pkg::MODE_END_PASS;
        end
      end
      rtf_txt_pkg::MODE_PASS: begin
        if (byte_i == rtf_txt_pkg::CH_NUL) mode_n = rtf_txt_pkg::MODE_END_PASS;
      end
      rtf_txt_pkg::MODE_TEXT: begin
        if (byte_i == rtf_txt_pkg::CH_NUL) begin
          mode_n = rtf_txt_pkg::MODE_END_RTF;
        end else if (byte_i == rtf_txt_pkg::CH_BSLASH) begin
          mode_n  = rtf_txt_pkg::MODE_ESCAPE;
          wp_n    = 4'd0;
          alive_n = '1;
        end
      end
      rtf_txt_pkg::MODE_ESCAPE: begin
        if (byte_i == rtf_txt_pkg::CH_NUL) begin
          mode_n = rtf_txt_pkg::MODE_END_RTF;
        end else if (esc_literal || byte_i == rtf_txt_pkg::CH_SPACE) begin
          mode_n = rtf_txt_pkg::MODE_TEXT;
        end else if (byte_i == rtf_txt_pkg::CH_BSLASH) begin
          wp_n    = 4'd0;
          alive_n = '1;
        end else if (grp_done) begin
          mode_n  = rtf_txt_pkg::MODE_GROUP;
          nest_n  = NEST_BITS'(1);
          alive_n = '0;
        end else if (quote_done) begin
          mode_n  = rtf_txt_pkg::MODE_TEXT;
          alive_n = '0;
        end else begin
          alive_n = (tab_done || par_done) ? '0 : kw_hit;
          wp_n    = wp_inc;
        end
      end
      rtf_txt_pkg::MODE_GROUP: begin
        if (byte_i == rtf_txt_pkg::CH_NUL) begin
          mode_n = rtf_txt_pkg::MODE_END_RTF;
        end else if (byte_i == rtf_txt_pkg::CH_LBRACE) begin
          if (nest_q != '1) nest_n = nest_q + NEST_BITS'(1);
        end else if (byte_i == rtf_txt_pkg::CH_RBRACE) begin
          nest_n = nest_dec;
          if (nest_dec == '0) mode_n = rtf_txt_pkg::MODE_TEXT;
        end
      end
      default: begin
        mode_n = mode_q;
      end
    endcase
  end

  // end of document puts everything back to the reset state
  always_comb begin
    if (last_i) begin
      mode_d  = rtf_txt_pkg::MODE_HEADER;
      hc_d    = 3'd0;
      wp_d    = 4'd0;
      alive_d = '0;
      nest_d  = '0;
    end else begin
      mode_d  = mode_n;
      hc_d    = hc_n;
      wp_d    = wp_n;
      alive_d = alive_n;
      nest_d  = nest_n;
    end
  end

  // emitted bytes
  always_comb begin
    emit_o = '0;
    for (int i = 0; i < rtf_txt_pkg::HEAD_LEN - 1; i++) begin
      emit_o.bytes[i] = rtf_txt_pkg::HEAD_TEXT[i];
    end
    case (mode_q)
      rtf_txt_pkg::MODE_HEADER: begin
        if (head_match) begin
          // short document: held header bytes go out as they are
          if (last_i && hc_inc < 3'(rtf_txt_pkg::HEAD_LEN)) emit_o.cnt = hc_inc;
        end else if (byte_i != rtf_txt_pkg::CH_NUL) begin
          emit_o.bytes[hc_q] = byte_i;
          emit_o.cnt         = hc_inc;
        end else begin
          emit_o.cnt = hc_q;
        end
      end
      rtf_txt_pkg::MODE_PASS: begin
        if (byte_i != rtf_txt_pkg::CH_NUL) begin
          emit_o.bytes[0] = byte_i;
          emit_o.cnt      = 3'd1;
        end
      end
      rtf_txt_pkg::MODE_TEXT: begin
        if (byte_i != rtf_txt_pkg::CH_NUL && byte_i != rtf_txt_pkg::CH_BSLASH
            && byte_i != rtf_txt_pkg::CH_LBRACE && byte_i != rtf_txt_pkg::CH_RBRACE
            && byte_i != rtf_txt_pkg::CH_LF) begin
          emit_o.bytes[0] = byte_i;
          emit_o.cnt      = 3'd1;
        end
      end
      rtf_txt_pkg::MODE_ESCAPE: begin
        if (byte_i == rtf_txt_pkg::CH_NUL) begin
          emit_o.cnt = 3'd0;
        end else if (esc_literal) begin
          emit_o.bytes[0] = byte_i;
          emit_o.cnt      = 3'd1;
        end else if (byte_i == rtf_txt_pkg::CH_SPACE || byte_i == rtf_txt_pkg::CH_BSLASH
                     || grp_done) begin
          emit_o.cnt = 3'd0;
        end else if (quote_done) begin
          emit_o.bytes[0] = rtf_txt_pkg::CH_SPACE;
          emit_o.cnt      = 3'd1;
        end else if (tab_done) begin
          emit_o.bytes[0] = rtf_txt_pkg::CH_TAB;
          emit_o.cnt      = 3'd1;
        end else if (par_done) begin
          emit_o.bytes[0] = rtf_txt_pkg::CH_LF;
          emit_o.cnt      = 3'd1;
        end
      end
      default: begin
        emit_o.cnt = 3'd0;
      end
    endcase
    emit_o.rtf = (mode_n == rtf_txt_pkg::MODE_TEXT) || (mode_n == rtf_txt_pkg::MODE_ESCAPE)
              || (mode_n == rtf_txt_pkg::MODE_GROUP) || (mode_n == rtf_txt_pkg::MODE_END_RTF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rtf_txt_pkg::MODE_HEADER;
      hc_q    <= 3'd0;
      wp_q    <= 4'd0;
      alive_q <= '0;
      nest_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      hc_q    <= hc_d;
      wp_q    <= wp_d;
      alive_q <= alive_d;
      nest_q  <= nest_d;
    end
  end

endmodule

`default_nettype wire

// File: src/rtf_to_text_filter_top.sv
// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+------------------------------------
// in       | input     | in_valid_i / in_stall_o     | in_byte_i, in_last_i
// res      | output    | res_valid_o / res_stall_i   | out_byte_o, out_valid_o,
//          |           |                             | out_last_o, is_rtf_o
//
// a byte is registered on its transfer and parsed from the input register once the
// result register is free, which takes its results; one byte per cycle when res is not
// stalled and each byte gives at most one result; a byte giving more (up to 5, header
// bytes flushed on a mismatch) holds the result register until all have transferred
// rst_ni clears the parser state, the input register valid and the result register valid
// a stall on res holds the result register, which then stalls in once a byte is waiting

`default_nettype none

module rtf_to_text_filter_top #(
  parameter int unsigned NEST_BITS = rtf_txt_pkg::NEST_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic            out_last_o,
  output logic            is_rtf_o
);

  localparam int unsigned CW = rtf_txt_pkg::CNT_W;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_xfer;

  // result register: every byte one document byte produced, drained one per transfer
  rtf_txt_pkg::emit_t emit;
  rtf_txt_pkg::emit_t bnd_q, bnd_d;
  logic               bnd_valid_q, bnd_valid_d;
  logic               bnd_last_q;
  logic               bnd_empty_q;
  logic [CW-1:0]      idx_q, idx_d;
  logic               bnd_load, bnd_done, bnd_free;
  logic               res_xfer, step;

  assign res_xfer = bnd_valid_q && !res_stall_i;
  assign bnd_done = res_xfer && (idx_q == bnd_q.cnt - CW'(1));
  assign bnd_free = !bnd_valid_q || bnd_done;

  // parse the waiting byte when its results have a place to go
  assign step       = in_valid_q && bnd_free;
  assign in_stall_o = in_valid_q && !bnd_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  rtf_txt_parser #(
    .NEST_BITS(NEST_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .emit_o (emit)
  );

  // a last byte with nothing to say still gets one empty result carrying the last flag
  assign bnd_load = step && ((emit.cnt != '0) || in_last_q);

  always_comb begin
    bnd_d = emit;
    if (emit.cnt == '0) bnd_d.cnt = CW'(1);
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    bnd_valid_d = bnd_valid_q;
    idx_d       = idx_q;
    if (bnd_load) begin
      bnd_valid_d = 1'b1;
      idx_d       = '0;
    end else if (bnd_done) begin
      bnd_valid_d = 1'b0;
    end else if (res_xfer) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      bnd_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      bnd_valid_q <= bnd_valid_d;
      idx_q       <= idx_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (bnd_load) begin
      bnd_q       <= bnd_d;
      bnd_last_q  <= in_last_q;
      bnd_empty_q <= (emit.cnt == '0);
    end
  end

  assign res_valid_o = bnd_valid_q;
  assign out_byte_o  = bnd_empty_q ? 8'h00 : bnd_q.bytes[idx_q];
  assign out_valid_o = !bnd_empty_q;
  assign out_last_o  = bnd_last_q && (idx_q == bnd_q.cnt - CW'(1));
  assign is_rtf_o    = bnd_q.rtf;

  // drain index stays inside the stored results
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_valid_q |-> (idx_q < bnd_q.cnt))
    else $error("result index past stored count");

  // a byte waiting on a busy result register is kept as it was
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_stall_o) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("stalled input byte lost or changed");

  // an empty result only ever stands alone as the end of a document
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bnd_valid_q && !out_valid_o) |-> (out_last_o && idx_q == '0))
    else $error("empty result that does not close the document");

endmodule

`default_nettype wire
